@@ sv/otpl_pkg.sv @@
// ----------------------------------------------------------------------------
// otpl_pkg
// shared types and constants for the optimal trade position labeler
// ----------------------------------------------------------------------------
package otpl_pkg;

   localparam int unsigned MAX_SAMPLES_DEF = 64;
   localparam int unsigned QUEUE_DEPTH     = 4;

   localparam int FEE_W    = 31;
   localparam int PRICE_W  = 32;
   localparam int VAL_W    = 48;
   localparam int SUM_W    = 50;
   localparam int CHOICE_W = 6;

   localparam logic [FEE_W-1:0] FEE_RESET = 31'd128;

   // positions
   localparam logic [1:0] POS_SHORT = 2'd0;
   localparam logic [1:0] POS_FLAT  = 2'd1;
   localparam logic [1:0] POS_LONG  = 2'd2;

   // actions, two-bit signed
   localparam logic [1:0] ACT_HOLD = 2'b00;
   localparam logic [1:0] ACT_BUY  = 2'b01;
   localparam logic [1:0] ACT_SELL = 2'b11;

   typedef struct packed {
      logic signed [PRICE_W-1:0] ask_price;
      logic signed [PRICE_W-1:0] bid_price;
      logic                      final_sample;
   } req_type;

   typedef struct packed {
      logic signed [1:0]       trade_action;
      logic signed [VAL_W-1:0] total_profit;
      logic                    final_action;
   } rsp_type;

   // one classified sample on its way to the back end
   typedef struct packed {
      logic signed [PRICE_W-1:0] ask_price;
      logic signed [PRICE_W-1:0] bid_price;
      logic [CHOICE_W-1:0]       choice;
      logic                      last;
      logic signed [VAL_W-1:0]   profit;
   } rec_type;

endpackage

@@ sv/otpl_front.sv @@
// ----------------------------------------------------------------------------
// otpl_front
// per-sample profit recursion over short, flat and long positions
// ----------------------------------------------------------------------------
module otpl_front #(
   parameter int unsigned MAX_SAMPLES = otpl_pkg::MAX_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  otpl_pkg::req_type             req_data,
   input  logic                          csr_wr_en,
   input  logic [otpl_pkg::FEE_W-1:0]    csr_wr_data,
   output logic                          rec_push,
   output otpl_pkg::rec_type             rec_data,
   input  logic                          rec_full
);
   import otpl_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);

   localparam logic signed [SUM_W-1:0] SAT_MAX =
      $signed({{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] SAT_MIN =
      $signed({{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});

   typedef struct packed {
      logic signed [VAL_W-1:0] val;
      logic [1:0]              from;
   } pick_type;

   function automatic logic signed [VAL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > SAT_MAX) r = SAT_MAX;
      if (v < SAT_MIN) r = SAT_MIN;
      return r[VAL_W-1:0];
   endfunction

   // ties go to the later candidate
   function automatic pick_type pick3(
      input logic signed [VAL_W-1:0] c0, input logic [1:0] s0,
      input logic signed [VAL_W-1:0] c1, input logic [1:0] s1,
      input logic signed [VAL_W-1:0] c2, input logic [1:0] s2);
      pick_type p;
      p.val  = c0;
      p.from = s0;
      if (c1 >= p.val) begin
         p.val  = c1;
         p.from = s1;
      end
      if (c2 >= p.val) begin
         p.val  = c2;
         p.from = s2;
      end
      return p;
   endfunction

   logic [FEE_W-1:0]        trade_fee_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [VAL_W-1:0] short_ff, flat_ff, long_ff;
   logic signed [VAL_W-1:0] short_in, flat_in, long_in;

   logic signed [SUM_W-1:0] ax, bx, ax2, bx2, feex, shx, flx, lgx;
   logic                    first, last;
   pick_type                pl, pf, ps;
   logic [CHOICE_W-1:0]     choice;

   assign ax   = SUM_W'(req_data.ask_price);
   assign bx   = SUM_W'(req_data.bid_price);
   assign ax2  = ax <<< 1;
   assign bx2  = bx <<< 1;
   assign feex = $signed({{(SUM_W-FEE_W){1'b0}}, trade_fee_ff});
   assign shx  = SUM_W'(short_ff);
   assign flx  = SUM_W'(flat_ff);
   assign lgx  = SUM_W'(long_ff);

   assign first = (count_ff == '0);
   assign last  = req_data.final_sample || (count_ff == CW'(MAX_SAMPLES - 1));

   assign req_stall = rec_full;
   assign rec_push  = req_valid && !rec_full;

   always_comb begin
      pl = pick3(long_ff, POS_LONG, sat(flx - ax - feex), POS_FLAT,
                 sat(shx - ax2 - feex), POS_SHORT);
      pf = pick3(flat_ff, POS_FLAT, sat(lgx + bx - feex), POS_LONG,
                 sat(shx - ax - feex), POS_SHORT);
      ps = pick3(short_ff, POS_SHORT, sat(lgx + bx2 - feex), POS_LONG,
                 sat(flx + bx - feex), POS_FLAT);
      if (first) begin
         short_in = sat(bx - feex);
         flat_in  = '0;
         long_in  = sat(-ax - feex);
         choice   = '0;
      end else begin
         short_in = ps.val;
         flat_in  = pf.val;
         long_in  = pl.val;
         choice   = {pl.from, pf.from, ps.from};
      end
      count_in = last ? '0 : count_ff + CW'(1);

      rec_data.ask_price = req_data.ask_price;
      rec_data.bid_price = req_data.bid_price;
      rec_data.choice    = choice;
      rec_data.last      = last;
      rec_data.profit    = flat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trade_fee_ff <= FEE_RESET;
         count_ff     <= '0;
         short_ff     <= '0;
         flat_ff      <= '0;
         long_ff      <= '0;
      end else begin
         if (csr_wr_en) trade_fee_ff <= csr_wr_data;
         if (rec_push) begin
            count_ff <= count_in;
            short_ff <= short_in;
            flat_ff  <= flat_in;
            long_ff  <= long_in;
         end
      end
   end

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (rec_push && rec_data.last) |=> (count_ff == '0))
      else $error("sample count not restarted after last sample");

endmodule

@@ sv/otpl_fifo.sv @@
// ----------------------------------------------------------------------------
// otpl_fifo
// short queue of classified samples between front and back end
// ----------------------------------------------------------------------------
module otpl_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  otpl_pkg::rec_type push_data,
   output logic              full,
   input  logic              pop,
   output otpl_pkg::rec_type pop_data,
   output logic              pop_valid
);
   import otpl_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   rec_type        q_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wp_ff, rp_ff;
   logic [PW:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + (PW+1)'(1);
      if (pop && !push) cnt_in = cnt_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + PW'(1);
         if (pop)  rp_ff <= rp_ff + PW'(1);
         cnt_ff <= cnt_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("queue written while full");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

endmodule

@@ sv/otpl_back.sv @@
// ----------------------------------------------------------------------------
// otpl_back
// sample stores, traceback, equal-price spreading and result output
// ----------------------------------------------------------------------------
module otpl_back #(
   parameter int unsigned MAX_SAMPLES = otpl_pkg::MAX_SAMPLES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  otpl_pkg::rec_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output otpl_pkg::rsp_type rsp_data
);
   import otpl_pkg::*;

   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);

   typedef enum logic [3:0] {
      ST_LOAD, ST_TR_RD, ST_TR_WB, ST_SP_RD, ST_SP_CHK, ST_BK_RD, ST_BK_CHK,
      ST_FW_RD, ST_FW_CHK, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
   } state_type;

   // memories
   logic [PRICE_W-1:0]  ask_mem    [MAX_SAMPLES];
   logic [PRICE_W-1:0]  bid_mem    [MAX_SAMPLES];
   logic [CHOICE_W-1:0] choice_mem [MAX_SAMPLES];
   logic [1:0]          act_mem    [MAX_SAMPLES];

   logic [PRICE_W-1:0]  ask_rd_ff, bid_rd_ff;
   logic [CHOICE_W-1:0] choice_rd_ff;
   logic [1:0]          act_rd_ff;

   state_type               state_ff, state_in;
   logic [CW-1:0]           wr_idx_ff, wr_idx_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [CW-1:0]           k_ff, k_in;
   logic [CW-1:0]           j_ff, j_in;
   logic [1:0]              pos_ff, pos_in;
   logic [1:0]              val_ff, val_in;
   logic [PRICE_W-1:0]      refp_ff, refp_in;
   logic signed [VAL_W-1:0] profit_ff, profit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [AW-1:0]      rd_addr;
   logic               act_we;
   logic [AW-1:0]      act_wa;
   logic [1:0]         act_wd;
   logic [1:0]         c;
   logic [PRICE_W-1:0] price;

   function automatic logic [1:0] step_act(input logic [1:0] p, input logic [1:0] prev);
      logic [1:0] r;
      if (p == prev)     r = ACT_HOLD;
      else if (p > prev) r = ACT_BUY;
      else               r = ACT_SELL;
      return r;
   endfunction

   assign q_pop     = q_valid && (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      refp_in      = refp_ff;
      profit_in    = profit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = k_ff[AW-1:0];
      act_we       = 1'b0;
      act_wa       = k_ff[AW-1:0];
      act_wd       = ACT_HOLD;
      c            = choice_rd_ff[{pos_ff, 1'b0} +: 2];
      if (c == 2'd3) c = POS_FLAT;
      price        = (val_ff == ACT_BUY) ? ask_rd_ff : bid_rd_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               if (q_data.last) begin
                  n_in      = wr_idx_ff + CW'(1);
                  k_in      = wr_idx_ff;
                  profit_in = q_data.profit;
                  pos_in    = POS_FLAT;
                  wr_idx_in = '0;
                  state_in  = ST_TR_RD;
               end else begin
                  wr_idx_in = wr_idx_ff + CW'(1);
               end
            end
         end
         ST_TR_RD: begin
            if (k_ff == '0) begin
               act_we   = 1'b1;
               act_wd   = step_act(pos_ff, POS_FLAT);
               state_in = ST_SP_RD;
            end else begin
               state_in = ST_TR_WB;
            end
         end
         ST_TR_WB: begin
            act_we   = 1'b1;
            act_wd   = step_act(pos_ff, c);
            pos_in   = c;
            k_in     = k_ff - CW'(1);
            state_in = ST_TR_RD;
         end
         ST_SP_RD: begin
            if (k_ff == n_ff) begin
               k_in     = '0;
               state_in = ST_EM_RD;
            end else begin
               state_in = ST_SP_CHK;
            end
         end
         ST_SP_CHK: begin
            if (act_rd_ff == ACT_HOLD) begin
               k_in     = k_ff + CW'(1);
               state_in = ST_SP_RD;
            end else begin
               val_in  = act_rd_ff;
               refp_in = (act_rd_ff == ACT_BUY) ? ask_rd_ff : bid_rd_ff;
               if (k_ff == '0) begin
                  j_in     = k_ff + CW'(1);
                  state_in = ST_FW_RD;
               end else begin
                  j_in     = k_ff - CW'(1);
                  state_in = ST_BK_RD;
               end
            end
         end
         ST_BK_RD: begin
            rd_addr  = j_ff[AW-1:0];
            state_in = ST_BK_CHK;
         end
         ST_BK_CHK: begin
            if (price == refp_ff) begin
               act_we = 1'b1;
               act_wa = j_ff[AW-1:0];
               act_wd = val_ff;
               if (j_ff == '0) begin
                  j_in     = k_ff + CW'(1);
                  state_in = ST_FW_RD;
               end else begin
                  j_in     = j_ff - CW'(1);
                  state_in = ST_BK_RD;
               end
            end else begin
               j_in     = k_ff + CW'(1);
               state_in = ST_FW_RD;
            end
         end
         ST_FW_RD: begin
            rd_addr = j_ff[AW-1:0];
            if (j_ff == n_ff) begin
               k_in     = j_ff;
               state_in = ST_SP_RD;
            end else begin
               state_in = ST_FW_CHK;
            end
         end
         ST_FW_CHK: begin
            if (price == refp_ff) begin
               act_we   = 1'b1;
               act_wa   = j_ff[AW-1:0];
               act_wd   = val_ff;
               j_in     = j_ff + CW'(1);
               state_in = ST_FW_RD;
            end else begin
               k_in     = j_ff;
               state_in = ST_SP_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.trade_action = act_rd_ff;
            rsp_data_in.total_profit = profit_ff;
            rsp_data_in.final_action = (k_ff == n_ff - CW'(1));
            state_in                 = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == n_ff - CW'(1)) begin
                  k_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // sample stores
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ask_mem[wr_idx_ff[AW-1:0]]    <= q_data.ask_price;
         bid_mem[wr_idx_ff[AW-1:0]]    <= q_data.bid_price;
         choice_mem[wr_idx_ff[AW-1:0]] <= q_data.choice;
      end
      ask_rd_ff    <= ask_mem[rd_addr];
      bid_rd_ff    <= bid_mem[rd_addr];
      choice_rd_ff <= choice_mem[rd_addr];
   end

   // action store
   always_ff @(posedge clock) begin
      if (act_we) act_mem[act_wa] <= act_wd;
      act_rd_ff <= act_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         wr_idx_ff    <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         pos_ff       <= POS_FLAT;
         val_ff       <= ACT_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         pos_ff       <= pos_in;
         val_ff       <= val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      refp_ff     <= refp_in;
      profit_ff   <= profit_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_trace_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TR_WB) |-> (k_ff != '0 && k_ff < n_ff))
      else $error("traceback index out of range");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SP_CHK || state_ff == ST_FW_CHK) |-> (j_ff < n_ff || k_ff < n_ff))
      else $error("spread scan beyond sequence");

   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EM_WAIT))
      else $error("result word outside output phase");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !q_pop)
      else $error("queue drained during traceback");

endmodule

@@ sv/optimal_trade_position_labeler_unit.sv @@
// ----------------------------------------------------------------------------
// optimal_trade_position_labeler_unit
// labels each price sample with its optimal buy, hold or sell action
// ----------------------------------------------------------------------------
// sequence: a sample word enters the queue at its accepting edge; for each sequence
//   the back end then stores the samples, traces the choices back, scans the held
//   samples and spreads each action over equal neighbours, then sends the result words
// throughput: one sample word a cycle while the four-entry queue has room; the
//   back end's single read port into the sample stores sets the sequence rate
// reset: synchronous, clears control state and sets the fee to 128 (0.5)
// ----------------------------------------------------------------------------
module optimal_trade_position_labeler_unit #(
   parameter int unsigned MAX_SAMPLES = otpl_pkg::MAX_SAMPLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // sample words
   input  logic                       req_valid,
   output logic                       req_stall,
   input  otpl_pkg::req_type          req_data,
   // result words
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output otpl_pkg::rsp_type          rsp_data,
   // fee register
   input  logic                       csr_wr_en,
   input  logic [otpl_pkg::FEE_W-1:0] csr_wr_data
);
   import otpl_pkg::*;

   // queue between the recursion and the traceback sequencer
   logic    rec_push, rec_full, rec_pop, rec_valid;
   rec_type rec_in, rec_out;

   // front: fee register and three-position profit recursion, one sample a cycle
   // while the queue has room; each sample leaves with predecessor choices and flat profit
   otpl_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rec_push    (rec_push),
      .rec_data    (rec_in),
      .rec_full    (rec_full)
   );

   // lets the front keep taking samples of the next sequence while the back
   // end is still busy with the traceback of the previous one
   otpl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_data  (rec_out),
      .pop_valid (rec_valid)
   );

   // back: stores the samples, walks the choices backwards from flat, spreads
   // actions over equal prices and sends one result word per sample
   otpl_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (rec_valid),
      .q_data    (rec_out),
      .q_pop     (rec_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the optimal trade position labeler: sequences of
// ask/bid samples are fed under random idling, results are predicted by a
// local profit recursion with traceback and spread, and checked word by word
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import otpl_pkg::*;

   localparam int NSAMP      = MAX_SAMPLES_DEF;
   localparam int SETTLE     = 800;     // back end drain time after last word
   localparam int STALL_LIMIT = 20000;  // cycles without any accepted word

   // expected result words and the labeler state that produces them
   class trade_label_board;
      rsp_type              expected_words[$];
      longint               fee = 128;
      logic signed [31:0]   asks[NSAMP];
      logic signed [31:0]   bids[NSAMP];
      logic [5:0]           choices[NSAMP];
      longint               best[3];
      int                   count = 0;
      int                   errors = 0;

      function longint sat48(longint v);
         longint hi;
         hi = 64'sh7FFF_FFFF_FFFF;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      // later candidate wins on a tie
      function longint pick3(longint c0, int s0, longint c1, int s1, longint c2, int s2,
                             output int from);
         longint b;
         b = c0; from = s0;
         if (c1 >= b) begin b = c1; from = s1; end
         if (c2 >= b) begin b = c2; from = s2; end
         return b;
      endfunction

      function void note_sample(req_type w);
         longint a, b, sh, fl, lg, profit;
         int idx, fs, ff, fg, n, k, j, c, dir;
         int pos[NSAMP];
         int act[NSAMP];
         rsp_type e;
         a = w.ask_price;
         b = w.bid_price;
         idx = (count >= NSAMP) ? 0 : count;
         asks[idx] = w.ask_price;
         bids[idx] = w.bid_price;
         if (idx == 0) begin
            best[POS_SHORT] = sat48(b - fee);
            best[POS_FLAT]  = 0;
            best[POS_LONG]  = sat48(-a - fee);
            choices[0] = '0;
         end else begin
            sh = best[POS_SHORT]; fl = best[POS_FLAT]; lg = best[POS_LONG];
            best[POS_LONG]  = pick3(lg, POS_LONG, sat48(fl - a - fee), POS_FLAT,
                                    sat48(sh - 2 * a - fee), POS_SHORT, fg);
            best[POS_FLAT]  = pick3(fl, POS_FLAT, sat48(lg + b - fee), POS_LONG,
                                    sat48(sh - a - fee), POS_SHORT, ff);
            best[POS_SHORT] = pick3(sh, POS_SHORT, sat48(lg + 2 * b - fee), POS_LONG,
                                    sat48(fl + b - fee), POS_FLAT, fs);
            choices[idx] = {fg[1:0], ff[1:0], fs[1:0]};
         end
         count = idx + 1;
         if (!w.final_sample && count < NSAMP) return;

         n = count;
         profit = best[POS_FLAT];
         // trace back from flat at the end
         pos[n-1] = POS_FLAT;
         for (k = n - 1; k > 0; k--) begin
            c = (choices[k] >> (2 * pos[k])) & 3;
            if (c > 2) c = POS_FLAT;
            pos[k-1] = c;
         end
         act[0] = pos[0] - 1;
         for (k = 1; k < n; k++)
            act[k] = (pos[k] == pos[k-1]) ? 0 : ((pos[k] > pos[k-1]) ? 1 : -1);
         // spread buys over equal asks, sells over equal bids
         k = 0;
         while (k < n) begin
            if (act[k] != 0) begin
               dir = act[k];
               j = k - 1;
               while (j >= 0 && ((dir > 0) ? asks[j] == asks[k] : bids[j] == bids[k])) begin
                  act[j] = dir; j--;
               end
               j = k + 1;
               while (j < n && ((dir > 0) ? asks[j] == asks[k] : bids[j] == bids[k])) begin
                  act[j] = dir; j++;
               end
               k = j;
            end else begin
               k++;
            end
         end
         for (k = 0; k < n; k++) begin
            e.trade_action = act[k][1:0];
            e.total_profit = profit[47:0];
            e.final_action = (k == n - 1);
            expected_words = {expected_words, e};
         end
         count = 0;
      endfunction

      function void check_word(rsp_type got);
         rsp_type e;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         if (got.trade_action !== e.trade_action) begin
            $error("trade_action expected %0d got %0d", e.trade_action, got.trade_action);
            errors++;
         end
         if (got.total_profit !== e.total_profit) begin
            $error("total_profit expected %0d got %0d", e.total_profit, got.total_profit);
            errors++;
         end
         if (got.final_action !== e.final_action) begin
            $error("final_action expected %0d got %0d", e.final_action, got.final_action);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [FEE_W-1:0] csr_wr_data = '0;

   trade_label_board board = new();
   int unsigned tx_idle_pct = 12;
   int unsigned rx_idle_pct = 58;
   int          quiet_cycles = 0;
   int          words_sent = 0;

   always #2 clock = ~clock;

   optimal_trade_position_labeler_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // monitor both channels, drive receiver stalls, and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_sample(req_data);
         if (rsp_valid && !rsp_stall) board.check_word(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // one sample word; valid stays high across back-to-back words
   task automatic send_sample(logic signed [31:0] ask, logic signed [31:0] bid, bit fin);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= '{ask_price: ask, bid_price: bid, final_sample: fin};
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // fee register is only touched with the block idle
   task automatic write_fee(logic [FEE_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.fee = value;
   endtask

   function automatic logic [FEE_W-1:0] pick_fee();
      unique case ($urandom_range(4))
         0: return '0;
         1: return {FEE_W{1'b1}};
         2: return 31'd128;
         3: return FEE_W'($urandom_range(2047));
         default: return FEE_W'($urandom);
      endcase
   endfunction

   // random walk around a base price so equal neighbours and ties show up
   task automatic random_sequence(int len, bit never_final);
      logic signed [31:0] ask, bid;
      int k;
      ask = $urandom_range(4000);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(9) == 0) begin
            ask = $urandom;
            bid = $urandom;
         end else begin
            if ($urandom_range(2) != 0) ask = ask + ($signed($urandom_range(4)) - 2) * 256;
            bid = ask - $urandom_range(2) * 128;
         end
         send_sample(ask, bid, !never_final && k == len - 1);
      end
   endtask

   task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int items, bit long_seq);
      int start;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start = words_sent;
      // saturating sequence: no final flag, the last slot ends it
      if (long_seq) random_sequence(NSAMP, 1'b1);
      while (words_sent - start < items) begin
         if ($urandom_range(3) == 0) write_fee(pick_fee());
         random_sequence($urandom_range(1, 12), 1'b0);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single sample at the price extremes, reset fee
      send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      // runs of equal asks and bids to exercise the spread
      send_sample(256, 0, 1'b0);
      send_sample(256, 0, 1'b0);
      send_sample(2048, 1792, 1'b0);
      send_sample(2048, 1792, 1'b0);
      send_sample(256, 0, 1'b0);
      send_sample(256, 0, 1'b1);
      // wild swings at the extremes
      send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
      // zero fee with flat prices: every candidate ties
      write_fee('0);
      send_sample(0, 0, 1'b0);
      send_sample(0, 0, 1'b0);
      send_sample(0, 0, 1'b1);
      // largest fee, against price swings wide enough to still trade
      write_fee({FEE_W{1'b1}});
      send_sample(-1, 32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, -1, 1'b0);
      send_sample(1000, 500, 1'b1);
      write_fee(31'd128);

      run_phase(12, 58, 70, 1'b1);
      run_phase(58, 12, 60, 1'b0);
      run_phase(0, 0, 60, 1'b0);

      drain();
      if (board.errors == 0 && board.expected_words.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
